### src/bafrc_pkg.sv
// Shared types, constants and helpers for the bit array range-count block.
package bafrc_pkg;

    localparam int POS_W      = 16;
    localparam int WORD_SHIFT = 6;
    localparam int WORD_W     = 64;
    localparam int WIDX_W     = POS_W - WORD_SHIFT;
    localparam int COUNT_W    = 17;
    localparam int POPC_W     = 7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TG_WRITE,
        ST_UP_WRITE,
        ST_PF_RUN,
        ST_RESULT
    } state_t;

    // population count of one 64-bit word, summed as a balanced adder tree
    function automatic logic [POPC_W-1:0] popcount64(input logic [WORD_W-1:0] w);
        logic [1:0] s1 [32];
        logic [2:0] s2 [16];
        logic [3:0] s3 [8];
        logic [4:0] s4 [4];
        logic [5:0] s5 [2];
        for (int i = 0; i < 32; i++)
        begin
            s1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        end
        return {1'b0, s5[0]} + {1'b0, s5[1]};
    endfunction

endpackage

### src/bit_array_flip_range_count_top.sv
// Top level of the blocked bit array with toggle and range population count.
//
//  channel | direction | handshake          | beat payload
//  --------+-----------+--------------------+-------------------------------------
//  input   | in        | in_valid/in_ready  | kind, first_position, last_position
//  output  | out       | out_valid/out_ready| lit_count
//
// After reset a clearing pass zeroes both memories; in_ready stays low during
// it. A toggle reads the word, writes it back flipped, then writes each node on
// the tree update path (at most log2(BLOCKS) + 1 nodes). A count forms one or
// two prefix sums, each scanning the words of a partial block while walking
// tree nodes, with one read a cycle on each memory port. A count stalls at the
// end only while the previous result still waits in the output register.
module bit_array_flip_range_count_top #(
    parameter int POSITIONS   = 65536,
    parameter int BLOCK_SHIFT = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [bafrc_pkg::POS_W-1:0]   first_position,
    input  logic [bafrc_pkg::POS_W-1:0]   last_position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bafrc_pkg::COUNT_W-1:0] lit_count
);

    localparam int WORDS  = (POSITIONS + 63) >> 6;
    localparam int BLOCKS = (POSITIONS + (1 << BLOCK_SHIFT) - 1) >> BLOCK_SHIFT;
    localparam int WAW    = $clog2(WORDS);
    localparam int TNW    = $clog2(BLOCKS + 1);

    logic                          w_we, w_re;
    logic [WAW-1:0]                w_waddr, w_raddr;
    logic [bafrc_pkg::WORD_W-1:0]  w_wdata, w_rdata;
    logic                          t_we, t_re;
    logic [TNW-1:0]                t_waddr, t_raddr;
    logic [bafrc_pkg::COUNT_W-1:0] t_wdata, t_rdata;

    // bit store, 64 bits per word
    bafrc_ram #(
        .WIDTH (bafrc_pkg::WORD_W),
        .DEPTH (WORDS),
        .AW    (WAW)
    ) u_bit_store (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .re    (w_re),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // per-block count tree, node 0 unused
    bafrc_ram #(
        .WIDTH (bafrc_pkg::COUNT_W),
        .DEPTH (BLOCKS + 1),
        .AW    (TNW)
    ) u_count_tree (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // sequencer
    bafrc_ctrl #(
        .POSITIONS   (POSITIONS),
        .BLOCK_SHIFT (BLOCK_SHIFT),
        .WORDS       (WORDS),
        .BLOCKS      (BLOCKS),
        .WAW         (WAW),
        .TNW         (TNW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .first_position (first_position),
        .last_position  (last_position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lit_count      (lit_count),
        .w_we           (w_we),
        .w_waddr        (w_waddr),
        .w_wdata        (w_wdata),
        .w_re           (w_re),
        .w_raddr        (w_raddr),
        .w_rdata        (w_rdata),
        .t_we           (t_we),
        .t_waddr        (t_waddr),
        .t_wdata        (t_wdata),
        .t_re           (t_re),
        .t_raddr        (t_raddr),
        .t_rdata        (t_rdata)
    );

endmodule

### src/bafrc_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
module bafrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/bafrc_ctrl.sv
// Sequencer and datapath: clearing pass, toggle with tree update, range query.
module bafrc_ctrl #(
    parameter int POSITIONS   = 65536,
    parameter int BLOCK_SHIFT = 6,
    parameter int WORDS       = (POSITIONS + 63) >> 6,
    parameter int BLOCKS      = (POSITIONS + (1 << BLOCK_SHIFT) - 1) >> BLOCK_SHIFT,
    parameter int WAW         = $clog2(WORDS),
    parameter int TNW         = $clog2(BLOCKS + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [bafrc_pkg::POS_W-1:0]      first_position,
    input  logic [bafrc_pkg::POS_W-1:0]      last_position,
    // output channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bafrc_pkg::COUNT_W-1:0]    lit_count,
    // bit store RAM
    output logic                             w_we,
    output logic [WAW-1:0]                   w_waddr,
    output logic [bafrc_pkg::WORD_W-1:0]     w_wdata,
    output logic                             w_re,
    output logic [WAW-1:0]                   w_raddr,
    input  logic [bafrc_pkg::WORD_W-1:0]     w_rdata,
    // count tree RAM
    output logic                             t_we,
    output logic [TNW-1:0]                   t_waddr,
    output logic [bafrc_pkg::COUNT_W-1:0]    t_wdata,
    output logic                             t_re,
    output logic [TNW-1:0]                   t_raddr,
    input  logic [bafrc_pkg::COUNT_W-1:0]    t_rdata
);

    localparam int POS_W   = bafrc_pkg::POS_W;
    localparam int WIDX_W  = bafrc_pkg::WIDX_W;
    localparam int WORD_W  = bafrc_pkg::WORD_W;
    localparam int COUNT_W = bafrc_pkg::COUNT_W;
    localparam int CLR_N   = (WORDS > BLOCKS + 1) ? WORDS : BLOCKS + 1;
    localparam int CLW     = $clog2(CLR_N);

    bafrc_pkg::state_t state_reg, state_next;

    logic [CLW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]   p_reg, p_next;
    logic [POS_W-1:0]   lo_reg, lo_next;
    logic               second_reg, second_next;
    logic               phase_reg, phase_next;
    logic               inc_reg, inc_next;
    logic [WIDX_W-1:0]  wcur_reg, wcur_next;
    logic               wmore_reg, wmore_next;
    logic               wpend_reg, wpend_next;
    logic [WORD_W-1:0]  wmask_reg, wmask_next;
    logic [TNW-1:0]     node_reg, node_next;
    logic               tpend_reg, tpend_next;
    logic [COUNT_W-1:0] psum_reg, psum_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] lit_count_reg, lit_count_next;

    // query operand ordering and range clipping
    logic             in_acc;
    logic [POS_W-1:0] q_lo, q_hi, q_hi_sat;
    logic             q_lo_out, q_hi_out;

    assign in_acc   = in_valid && in_ready;
    assign q_lo     = (first_position > last_position) ? last_position : first_position;
    assign q_hi     = (first_position > last_position) ? first_position : last_position;
    assign q_lo_out = 32'(q_lo) >= POSITIONS;
    assign q_hi_out = 32'(q_hi) >= POSITIONS;
    assign q_hi_sat = q_hi_out ? POS_W'(POSITIONS - 1) : q_hi;

    // partial block scan: word range and per-word mask for the current prefix
    logic [POS_W-1:0]  bstart;
    logic [5:0]        lo_off, hi_off;
    logic [WORD_W-1:0] cur_mask;
    logic              pf_done;

    assign bstart   = (p_reg >> BLOCK_SHIFT) << BLOCK_SHIFT;
    assign lo_off   = (wcur_reg == bstart[POS_W-1:6]) ? bstart[5:0] : 6'd0;
    assign hi_off   = (wcur_reg == p_reg[POS_W-1:6]) ? p_reg[5:0] : 6'd63;
    assign cur_mask = ({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (6'd63 - hi_off));
    assign pf_done  = !wmore_reg && (node_reg == '0) && !wpend_reg && !tpend_reg;

    // tree walk helpers
    logic [TNW-1:0] node_low;
    logic [TNW:0]   node_up;

    assign node_low = node_reg & (~node_reg + TNW'(1));
    assign node_up  = {1'b0, node_reg} + {1'b0, node_low};

    // toggle helpers
    logic [WORD_W-1:0] tg_word;
    logic              tg_newbit;
    logic [POS_W-1:0]  tg_blk1;

    assign tg_word   = w_rdata ^ (WORD_W'(1) << p_reg[5:0]);
    assign tg_newbit = tg_word[p_reg[5:0]];
    assign tg_blk1   = (p_reg >> BLOCK_SHIFT) + POS_W'(1);

    // prefix start for the second (lower) bound
    logic [POS_W-1:0] lo_bstart;
    assign lo_bstart = (lo_reg >> BLOCK_SHIFT) << BLOCK_SHIFT;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bafrc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            wmore_reg     <= 1'b0;
            wpend_reg     <= 1'b0;
            tpend_reg     <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            wmore_reg     <= wmore_next;
            wpend_reg     <= wpend_next;
            tpend_reg     <= tpend_next;
            phase_reg     <= phase_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        lo_reg        <= lo_next;
        second_reg    <= second_next;
        inc_reg       <= inc_next;
        wcur_reg      <= wcur_next;
        wmask_reg     <= wmask_next;
        node_reg      <= node_next;
        psum_reg      <= psum_next;
        total_reg     <= total_next;
        res_reg       <= res_next;
        lit_count_reg <= lit_count_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bafrc_pkg::ST_CLEAR:
            begin
                if (int'(clr_cnt_reg) == CLR_N - 1)
                begin
                    state_next = bafrc_pkg::ST_IDLE;
                end
            end
            bafrc_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!kind)
                    begin
                        if (32'(first_position) < POSITIONS)
                        begin
                            state_next = bafrc_pkg::ST_TG_WRITE;
                        end
                    end
                    else if (q_lo_out)
                    begin
                        state_next = bafrc_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = bafrc_pkg::ST_PF_RUN;
                    end
                end
            end
            bafrc_pkg::ST_TG_WRITE:
            begin
                state_next = bafrc_pkg::ST_UP_WRITE;
            end
            bafrc_pkg::ST_UP_WRITE:
            begin
                if (32'(node_up) > BLOCKS)
                begin
                    state_next = bafrc_pkg::ST_IDLE;
                end
            end
            bafrc_pkg::ST_PF_RUN:
            begin
                if (pf_done && (phase_reg || !second_reg))
                begin
                    state_next = bafrc_pkg::ST_RESULT;
                end
            end
            bafrc_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = bafrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bafrc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        p_next         = p_reg;
        lo_next        = lo_reg;
        second_next    = second_reg;
        phase_next     = phase_reg;
        inc_next       = inc_reg;
        wcur_next      = wcur_reg;
        wmore_next     = wmore_reg;
        wpend_next     = 1'b0;
        wmask_next     = wmask_reg;
        node_next      = node_reg;
        tpend_next     = 1'b0;
        psum_next      = psum_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        lit_count_next = lit_count_reg;
        in_ready       = 1'b0;
        w_we           = 1'b0;
        w_waddr        = WAW'(p_reg[POS_W-1:6]);
        w_wdata        = tg_word;
        w_re           = 1'b0;
        w_raddr        = WAW'(wcur_reg);
        t_we           = 1'b0;
        t_waddr        = node_reg;
        t_wdata        = t_rdata + (inc_reg ? COUNT_W'(1) : {COUNT_W{1'b1}});
        t_re           = 1'b0;
        t_raddr        = node_reg;

        case (state_reg)
            bafrc_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + CLW'(1);
                w_we         = int'(clr_cnt_reg) < WORDS;
                w_waddr      = WAW'(clr_cnt_reg);
                w_wdata      = '0;
                t_we         = int'(clr_cnt_reg) < BLOCKS + 1;
                t_waddr      = TNW'(clr_cnt_reg);
                t_wdata      = '0;
            end
            bafrc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_acc)
                begin
                    if (!kind)
                    begin
                        // fetch the word holding the bit to flip
                        p_next  = first_position;
                        w_re    = 1'b1;
                        w_raddr = WAW'(first_position[POS_W-1:6]);
                    end
                    else
                    begin
                        res_next    = '0;
                        p_next      = q_hi_sat;
                        lo_next     = q_lo - POS_W'(1);
                        second_next = q_lo != '0;
                        phase_next  = 1'b0;
                        psum_next   = '0;
                        wcur_next   = WIDX_W'(((q_hi_sat >> BLOCK_SHIFT) << BLOCK_SHIFT) >> 6);
                        wmore_next  = 1'b1;
                        node_next   = TNW'(q_hi_sat >> BLOCK_SHIFT);
                    end
                end
            end
            bafrc_pkg::ST_TG_WRITE:
            begin
                // write flipped word, start the tree update at block + 1
                w_we      = 1'b1;
                inc_next  = tg_newbit;
                node_next = TNW'(tg_blk1);
                t_re      = 1'b1;
                t_raddr   = TNW'(tg_blk1);
            end
            bafrc_pkg::ST_UP_WRITE:
            begin
                // write this node, read the next one on the update path
                t_we = 1'b1;
                if (32'(node_up) <= BLOCKS)
                begin
                    node_next = TNW'(node_up);
                    t_re      = 1'b1;
                    t_raddr   = TNW'(node_up);
                end
            end
            bafrc_pkg::ST_PF_RUN:
            begin
                // fold in the beats read last cycle
                psum_next = psum_reg
                          + (wpend_reg ? COUNT_W'(bafrc_pkg::popcount64(w_rdata & wmask_reg))
                                       : COUNT_W'(0))
                          + (tpend_reg ? t_rdata : COUNT_W'(0));
                // scan the partial block one word a cycle
                if (wmore_reg)
                begin
                    w_re       = 1'b1;
                    wpend_next = 1'b1;
                    wmask_next = cur_mask;
                    wcur_next  = wcur_reg + WIDX_W'(1);
                    wmore_next = wcur_reg != p_reg[POS_W-1:6];
                end
                // walk the tree toward the root
                if (node_reg != '0)
                begin
                    t_re       = 1'b1;
                    tpend_next = 1'b1;
                    node_next  = node_reg - node_low;
                end
                if (pf_done)
                begin
                    if (!phase_reg)
                    begin
                        total_next = psum_reg;
                        res_next   = psum_reg;
                        if (second_reg)
                        begin
                            phase_next = 1'b1;
                            p_next     = lo_reg;
                            psum_next  = '0;
                            wcur_next  = WIDX_W'(lo_bstart >> 6);
                            wmore_next = 1'b1;
                            node_next  = TNW'(lo_reg >> BLOCK_SHIFT);
                        end
                    end
                    else
                    begin
                        res_next = total_reg - psum_reg;
                    end
                end
            end
            bafrc_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    lit_count_next = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign lit_count = lit_count_reg;

endmodule

### tb/sv/bit_array_flip_range_count_top_tb.sv
// Testbench for the bit array toggle and range population count block.
module bit_array_flip_range_count_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W       = bafrc_pkg::POS_W;
    localparam int COUNT_W     = bafrc_pkg::COUNT_W;
    localparam int POSITIONS   = 65536;
    localparam int BLOCK_SHIFT = 6;
    localparam int BLOCK_BITS  = 1 << BLOCK_SHIFT;
    localparam int BLOCKS      = POSITIONS >> BLOCK_SHIFT;
    localparam int MAX_WAIT    = 12;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT = 200000;

    // operation codes on the kind field
    localparam logic KIND_FLIP  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic [POS_W-1:0]   first_position;
    logic [POS_W-1:0]   last_position;
    logic               out_valid;
    logic               out_ready;
    logic [COUNT_W-1:0] lit_count;

    // shadow copy of the bit array and per-block lit counts
    bit               lit_bits [0:POSITIONS-1];
    int unsigned      block_lit [0:BLOCKS-1];
    logic [COUNT_W-1:0] expected_counts [$];

    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  tx_no_idle  = 1'b0;
    bit  rx_no_stall = 1'b0;

    bit_array_flip_range_count_top #(
        .POSITIONS   (POSITIONS),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .first_position (first_position),
        .last_position  (last_position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lit_count      (lit_count)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int draw_wait(input bit none);
        if (none)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // lit bits at positions 0..p: whole blocks below, then a scan of p's block
    function automatic int unsigned lit_up_to(input int unsigned p);
        int unsigned blk;
        int unsigned total;
        blk   = p >> BLOCK_SHIFT;
        total = 0;
        for (int unsigned b = 0; b < blk; b++)
            total += block_lit[b];
        for (int unsigned i = blk << BLOCK_SHIFT; i <= p; i++)
            total += lit_bits[i];
        return total;
    endfunction

    function automatic logic [COUNT_W-1:0] range_lit(input int unsigned lo_pos,
                                                      input int unsigned hi_pos);
        int unsigned tmp;
        int unsigned total;
        if (lo_pos > hi_pos)
        begin
            tmp    = lo_pos;
            lo_pos = hi_pos;
            hi_pos = tmp;
        end
        if (lo_pos >= POSITIONS)
            return '0;
        if (hi_pos >= POSITIONS)
            hi_pos = POSITIONS - 1;
        total = lit_up_to(hi_pos);
        if (lo_pos > 0)
            total -= lit_up_to(lo_pos - 1);
        return COUNT_W'(total);
    endfunction

    task automatic flip_shadow(input int unsigned pos);
        if (pos >= POSITIONS)
            return;
        lit_bits[pos] = ~lit_bits[pos];
        if (lit_bits[pos])
            block_lit[pos >> BLOCK_SHIFT]++;
        else
            block_lit[pos >> BLOCK_SHIFT]--;
    endtask

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                   input logic [COUNT_W-1:0] want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        fail_count++;
    endtask

    // send one input beat, then update the shadow state on acceptance
    task automatic send_beat(input logic k, input logic [POS_W-1:0] first_pos,
                             input logic [POS_W-1:0] last_pos);
        int gap;
        gap = draw_wait(tx_no_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        first_position <= first_pos;
        last_position  <= last_pos;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        if (k == KIND_COUNT)
            expected_counts = {expected_counts, range_lit(first_pos, last_pos)};
        else
            flip_shadow(first_pos);
    endtask

    // result receiver: random stall before each beat
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_wait(rx_no_stall);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_counts.size() == 0)
                report_mismatch("unexpected beat lit_count", lit_count, '0);
            else if (lit_count !== expected_counts[0])
                report_mismatch("lit_count", lit_count, expected_counts.pop_front());
            else
                void'(expected_counts.pop_front());
        end
    end

    // a query over an array that has never been written
    task automatic test_empty_array();
        send_beat(KIND_COUNT, 16'd0, 16'hFFFF);
        send_beat(KIND_COUNT, 16'hFFFF, 16'd0);
    endtask

    // bits on block edges and at both ends of the array
    task automatic test_block_edges();
        send_beat(KIND_FLIP, 16'd0, 16'hFFFF);
        send_beat(KIND_FLIP, 16'd63, 16'd0);
        send_beat(KIND_FLIP, 16'd64, 16'h5A5A);
        send_beat(KIND_FLIP, 16'hFFFF, 16'hA5A5);
        send_beat(KIND_FLIP, 16'h8000, 16'd0);
        send_beat(KIND_FLIP, 16'd1023, 16'd0);
        send_beat(KIND_COUNT, 16'd0, 16'hFFFF);
        send_beat(KIND_COUNT, 16'd63, 16'd64);
        send_beat(KIND_COUNT, 16'd64, 16'd127);
        send_beat(KIND_COUNT, 16'd1, 16'd62);
        send_beat(KIND_COUNT, 16'hFFFF, 16'hFFFF);
        send_beat(KIND_COUNT, 16'd0, 16'd0);
        send_beat(KIND_COUNT, 16'hFFC0, 16'hFFFE);
    endtask

    // start above end gets swapped
    task automatic test_reversed_range();
        send_beat(KIND_COUNT, 16'hFFFF, 16'd64);
        send_beat(KIND_COUNT, 16'd64, 16'd63);
        send_beat(KIND_COUNT, 16'd40000, 16'd100);
    endtask

    // toggling a lit bit clears it and takes one off its block
    task automatic test_clear_bits();
        send_beat(KIND_FLIP, 16'd63, 16'd0);
        send_beat(KIND_FLIP, 16'hFFFF, 16'd0);
        send_beat(KIND_COUNT, 16'd0, 16'hFFFF);
        send_beat(KIND_COUNT, 16'd63, 16'd63);
    endtask

    function automatic logic [POS_W-1:0] pick_position(input int unsigned hot_base);
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel <= 3)
            return POS_W'(hot_base + $urandom_range(0, 255));
        if (sel <= 5)
            return POS_W'($urandom_range(0, POSITIONS - 1));
        if (sel == 6)
        begin
            case ($urandom_range(0, 3))
                0: return POS_W'($urandom_range(0, BLOCKS - 1) << BLOCK_SHIFT);
                1: return POS_W'(($urandom_range(0, BLOCKS - 1) << BLOCK_SHIFT) + 1);
                2: return POS_W'(($urandom_range(0, BLOCKS - 1) << BLOCK_SHIFT) + 62);
                default: return POS_W'(($urandom_range(0, BLOCKS - 1) << BLOCK_SHIFT)
                                       + BLOCK_BITS - 1);
            endcase
        end
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    // mixed toggles and queries, half of the positions around a moving dense window
    task automatic test_random_traffic(input int items);
        int unsigned hot_base;
        int unsigned pace;
        for (int n = 0; n < items; n++)
        begin
            if (n % 50 == 0)
            begin
                pace        = $urandom_range(0, 3);
                tx_no_idle  = pace[0];
                rx_no_stall = pace[1];
                hot_base    = $urandom_range(0, POSITIONS - 256);
            end
            if ($urandom_range(0, 99) < 55)
                send_beat(KIND_FLIP, pick_position(hot_base), POS_W'($urandom));
            else
                send_beat(KIND_COUNT, pick_position(hot_base), pick_position(hot_base));
        end
        tx_no_idle  = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < POSITIONS; i++)
            lit_bits[i] = 1'b0;
        for (int b = 0; b < BLOCKS; b++)
            block_lit[b] = 0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        kind           <= KIND_FLIP;
        first_position <= '0;
        last_position  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_array();
        test_block_edges();
        test_reversed_range();
        test_clear_bits();
        test_random_traffic(450);

        // drain outstanding results, then let any trailing toggle finish
        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
